// File: sv/hbb_pkg.sv
package hbb_pkg;

  localparam int CHAN_W    = 8;
  localparam int JOB_DEPTH = 2;
  localparam int RES_DEPTH = 8;
  localparam int NUM_CHAN  = 3;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    pixel_t pix;
    logic   row_last;
  } result_t;

  localparam int PIX_W = $bits(pixel_t);
  localparam int RES_W = $bits(result_t);

  // channel 0 is red, 1 green, 2 blue
  function automatic logic [CHAN_W-1:0] chan_of(input pixel_t p, input int c);
    logic [PIX_W-1:0] bits;
    bits = p;
    return bits[PIX_W-1-c*CHAN_W -: CHAN_W];
  endfunction

endpackage

// File: sv/hbb_fifo.sv
module hbb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           push,
  input  logic                           pop,
  input  logic [WIDTH-1:0]               wdata,
  output logic [WIDTH-1:0]               rdata,
  output logic [$clog2(DEPTH+1)-1:0]     count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  // callers only push when not full and pop when not empty
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  assign rdata = mem_r[rd_ptr_r];
  assign count = count_r;

endmodule

// File: sv/hbb_front.sv
module hbb_front #(
  parameter int BLUR_RADIUS = 3
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                accept,
  input  hbb_pkg::pixel_t                     cur_pix,
  input  logic                                row_last,
  output logic                                job_valid,
  output hbb_pkg::pixel_t [2*BLUR_RADIUS:0]   job_win,
  output logic [$clog2(BLUR_RADIUS+1)-1:0]    job_rem
);

  import hbb_pkg::*;

  localparam int HIST = 2 * BLUR_RADIUS;
  localparam int TAPS = HIST + 1;
  localparam int IW   = $clog2(TAPS);
  localparam int RW   = $clog2(BLUR_RADIUS + 1);

  pixel_t [HIST-1:0] window_r, window_nxt;
  logic [IW-1:0]     row_pos_r, row_pos_nxt;

  pixel_t [HIST:0]   seq_raw;
  pixel_t [HIST:0]   seq;
  pixel_t            first_pix;
  logic [IW-1:0]     first;
  logic [RW-1:0]     off;

  always_comb begin
    for (int k = 0; k < HIST; k++) begin
      seq_raw[k] = window_r[k];
    end
    seq_raw[HIST] = cur_pix;

    // slots ahead of the row start copy the row's first pixel
    first     = IW'(HIST) - row_pos_r;
    first_pix = seq_raw[first];
    for (int k = 0; k <= HIST; k++) begin
      seq[k] = (k < int'(first)) ? first_pix : seq_raw[k];
    end

    if (row_last && (row_pos_r < IW'(BLUR_RADIUS))) begin
      off = RW'(BLUR_RADIUS - int'(row_pos_r));
    end else begin
      off = '0;
    end
    job_rem   = row_last ? (RW'(BLUR_RADIUS) - off) : '0;
    job_valid = row_last || (row_pos_r >= IW'(BLUR_RADIUS));

    // window aligned on the first centre; past the row end repeats the last pixel
    for (int j = 0; j <= HIST; j++) begin
      if (int'(off) + j > HIST) begin
        job_win[j] = cur_pix;
      end else begin
        job_win[j] = seq[IW'(int'(off) + j)];
      end
    end

    for (int k = 0; k < HIST; k++) begin
      window_nxt[k] = seq[k+1];
    end

    row_pos_nxt = row_pos_r;
    if (accept) begin
      if (row_last) begin
        row_pos_nxt = '0;
      end else if (row_pos_r != IW'(HIST)) begin
        row_pos_nxt = row_pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_pos_r <= '0;
    end else begin
      row_pos_r <= row_pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !row_last) begin
      window_r <= window_nxt;
    end
  end

endmodule

// File: sv/hbb_back.sv
module hbb_back #(
  parameter int BLUR_RADIUS = 3
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          job_empty,
  input  hbb_pkg::pixel_t [2*BLUR_RADIUS:0]             job_win,
  input  logic [$clog2(BLUR_RADIUS+1)-1:0]              job_rem,
  input  logic                                          job_last,
  output logic                                          job_pop,
  input  logic [$clog2(hbb_pkg::RES_DEPTH+1)-1:0]       res_count,
  output logic                                          res_push,
  output hbb_pkg::result_t                              res_data
);

  import hbb_pkg::*;

  localparam int HIST  = 2 * BLUR_RADIUS;
  localparam int TAPS  = HIST + 1;
  localparam int RW    = $clog2(BLUR_RADIUS + 1);
  localparam int SUMW  = $clog2(((1 << CHAN_W) - 1) * TAPS + 1);
  localparam int SHIFT = SUMW;
  localparam int RECIP = (1 << SHIFT) / TAPS;
  localparam int PW    = SUMW + SHIFT;

  // sequencer for multi-result jobs
  logic              busy_r, busy_nxt;
  pixel_t [HIST:0]   win_r, win_nxt;
  logic [RW-1:0]     rem_r, rem_nxt;
  logic              last_r, last_nxt;

  pixel_t [HIST:0]   taps;
  pixel_t [HIST:0]   shifted;
  logic [RW-1:0]     cur_rem;
  logic              cur_last;
  logic              credit;
  logic              issue;

  logic              s1_v_r, s2_v_r, s3_v_r;
  pixel_t [HIST:0]   s1_taps_r;
  logic              s1_last_r, s2_last_r, s3_last_r;
  logic [SUMW-1:0]   s2_sum_r [NUM_CHAN];
  logic [SUMW-1:0]   s3_sum_r [NUM_CHAN];
  logic [PW-1:0]     s3_prod_r [NUM_CHAN];

  logic [SUMW-1:0]   sum_c [NUM_CHAN];
  logic [PW-1:0]     prod_c [NUM_CHAN];
  logic [CHAN_W-1:0] quot_c [NUM_CHAN];
  logic [CHAN_W-1:0] q_est [NUM_CHAN];
  logic [SUMW-1:0]   resid [NUM_CHAN];

  // results in the pipe are counted against free space in the result queue
  assign credit = (int'(res_count) + int'(s1_v_r) + int'(s2_v_r) + int'(s3_v_r))
                  < RES_DEPTH;
  assign issue   = credit && (busy_r || !job_empty);
  assign job_pop = issue && !busy_r;

  always_comb begin
    taps     = busy_r ? win_r : job_win;
    cur_rem  = busy_r ? rem_r : job_rem;
    cur_last = busy_r ? last_r : job_last;

    for (int j = 0; j < HIST; j++) begin
      shifted[j] = taps[j+1];
    end
    shifted[HIST] = taps[HIST];

    busy_nxt = busy_r;
    win_nxt  = win_r;
    rem_nxt  = rem_r;
    last_nxt = last_r;
    if (issue) begin
      busy_nxt = (cur_rem != '0);
      win_nxt  = shifted;
      rem_nxt  = cur_rem - 1'b1;
      last_nxt = cur_last;
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      sum_c[c] = '0;
      for (int t = 0; t < TAPS; t++) begin
        sum_c[c] = sum_c[c] + SUMW'(chan_of(s1_taps_r[t], c));
      end
      prod_c[c] = PW'(s2_sum_r[c]) * PW'(RECIP);
      // reciprocal estimate is low by at most one
      q_est[c]  = s3_prod_r[c][SHIFT +: CHAN_W];
      resid[c]  = s3_sum_r[c] - SUMW'(SUMW'(q_est[c]) * SUMW'(TAPS));
      quot_c[c] = (resid[c] >= SUMW'(TAPS)) ? q_est[c] + 1'b1 : q_est[c];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      s1_v_r <= issue;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    win_r     <= win_nxt;
    rem_r     <= rem_nxt;
    last_r    <= last_nxt;
    s1_taps_r <= taps;
    s1_last_r <= cur_last && (cur_rem == '0);
    s2_last_r <= s1_last_r;
    s3_last_r <= s2_last_r;
    for (int c = 0; c < NUM_CHAN; c++) begin
      s2_sum_r[c]  <= sum_c[c];
      s3_sum_r[c]  <= s2_sum_r[c];
      s3_prod_r[c] <= prod_c[c];
    end
  end

  assign res_push           = s3_v_r;
  assign res_data.pix.red   = quot_c[0];
  assign res_data.pix.green = quot_c[1];
  assign res_data.pix.blue  = quot_c[2];
  assign res_data.row_last  = s3_last_r;

endmodule

// File: sv/horizontal_box_blur_rgb.sv
// Horizontal box blur over an RGB raster stream, 2*BLUR_RADIUS+1 taps per colour channel,
// with the first and last pixel of each row repeated past the row ends and each sum
// divided by the tap count and truncated. Results trail the input by BLUR_RADIUS pixels;
// the first BLUR_RADIUS pixels of a row give nothing, and the pixel flagged as row last
// releases all pending results of the row (up to BLUR_RADIUS+1), the final one flagged.
// One pixel is taken per clock while full is low; one result leaves per clock while pop is
// high and empty low. A row-end pixel needs one clock of the back-end window sequencer per
// result it releases while the result queue has room, so at row ends the two-entry job
// queue can fill and raise full. An issued result goes through tap select, channel sums,
// reciprocal multiply and remainder correction to the output queue, which holds eight results.
module horizontal_box_blur_rgb #(
  parameter int BLUR_RADIUS = 3
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_red_in,
  input  logic [7:0] in_green_in,
  input  logic [7:0] in_blue_in,
  input  logic       in_row_last_in,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_red_out,
  output logic [7:0] out_green_out,
  output logic [7:0] out_blue_out,
  output logic       out_row_last_out
);

  import hbb_pkg::*;

  localparam int HIST  = 2 * BLUR_RADIUS;
  localparam int TAPS  = HIST + 1;
  localparam int RW    = $clog2(BLUR_RADIUS + 1);
  localparam int JOB_W = TAPS * PIX_W + RW + 1;
  localparam int JCW   = $clog2(JOB_DEPTH + 1);
  localparam int RCW   = $clog2(RES_DEPTH + 1);

  logic              accept;
  pixel_t            cur_pix;
  logic              job_valid;
  pixel_t [HIST:0]   fr_win;
  logic [RW-1:0]     fr_rem;
  logic [JOB_W-1:0]  job_wdata, job_rdata;
  logic [JCW-1:0]    job_count;
  logic              job_pop;
  pixel_t [HIST:0]   bk_win;
  logic [RW-1:0]     bk_rem;
  logic              bk_last;
  logic [RCW-1:0]    res_count;
  logic              res_push;
  result_t           res_data, res_head;
  logic              res_pop;

  assign full   = (job_count == JCW'(JOB_DEPTH));
  assign accept = push && !full;

  assign cur_pix.red   = in_red_in;
  assign cur_pix.green = in_green_in;
  assign cur_pix.blue  = in_blue_in;

  hbb_front #(
    .BLUR_RADIUS(BLUR_RADIUS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .cur_pix   (cur_pix),
    .row_last  (in_row_last_in),
    .job_valid (job_valid),
    .job_win   (fr_win),
    .job_rem   (fr_rem)
  );

  assign job_wdata = {fr_win, fr_rem, in_row_last_in};

  hbb_fifo #(
    .WIDTH(JOB_W),
    .DEPTH(JOB_DEPTH)
  ) u_job_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (accept && job_valid),
    .pop   (job_pop),
    .wdata (job_wdata),
    .rdata (job_rdata),
    .count (job_count)
  );

  assign {bk_win, bk_rem, bk_last} = job_rdata;

  hbb_back #(
    .BLUR_RADIUS(BLUR_RADIUS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (job_count == '0),
    .job_win   (bk_win),
    .job_rem   (bk_rem),
    .job_last  (bk_last),
    .job_pop   (job_pop),
    .res_count (res_count),
    .res_push  (res_push),
    .res_data  (res_data)
  );

  assign empty   = (res_count == '0);
  assign res_pop = pop && !empty;

  hbb_fifo #(
    .WIDTH(RES_W),
    .DEPTH(RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .pop   (res_pop),
    .wdata (res_data),
    .rdata (res_head),
    .count (res_count)
  );

  assign out_red_out      = res_head.pix.red;
  assign out_green_out    = res_head.pix.green;
  assign out_blue_out     = res_head.pix.blue;
  assign out_row_last_out = res_head.row_last;

endmodule

// File: tb/horizontal_box_blur_rgb_test.sv
`timescale 1ns / 100ps

module horizontal_box_blur_rgb_test;
  import hbb_pkg::*;

  localparam int RADIUS      = 3;
  localparam int TAPS        = 2 * RADIUS + 1;
  localparam int HIST        = 2 * RADIUS;
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_REPORTS = 10;

  // expected blurred pixels, worked out from each accepted input pixel
  class blur_scoreboard;
    result_t blurred_q[$];
    pixel_t  window[HIST];
    pixel_t  span[TAPS];
    int      row_pos;
    int      failures;

    function new();
      row_pos  = 0;
      failures = 0;
    endfunction

    function result_t mean_at(int centre, logic last);
      int      sum_r, sum_g, sum_b, d, k;
      result_t r;
      sum_r = 0;
      sum_g = 0;
      sum_b = 0;
      for (d = -RADIUS; d <= RADIUS; d++) begin
        k = centre + d;
        if (k > HIST) k = HIST;
        if (k < 0) k = 0;
        sum_r += span[k].red;
        sum_g += span[k].green;
        sum_b += span[k].blue;
      end
      r.pix.red   = CHAN_W'(sum_r / TAPS);
      r.pix.green = CHAN_W'(sum_g / TAPS);
      r.pix.blue  = CHAN_W'(sum_b / TAPS);
      r.row_last  = last;
      return r;
    endfunction

    function void note_pixel(pixel_t px, logic row_last);
      int n, first, c0, c, k;
      n = (row_pos > HIST) ? HIST : row_pos;
      for (k = 0; k < HIST; k++) span[k] = window[k];
      span[HIST] = px;
      // taps before the row start repeat its first pixel
      first = HIST - n;
      for (k = 0; k < first; k++) span[k] = span[first];
      if (row_last) begin
        c0 = (first > RADIUS) ? first : RADIUS;
        for (c = c0; c <= HIST; c++) blurred_q.push_back(mean_at(c, c == HIST));
        row_pos = 0;
      end else begin
        if (n >= RADIUS) blurred_q.push_back(mean_at(RADIUS, 1'b0));
        for (k = 0; k < HIST; k++) window[k] = span[k + 1];
        row_pos = (n < HIST) ? n + 1 : HIST;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (blurred_q.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("%0t: unexpected result r=%0d g=%0d b=%0d last=%0b", $realtime,
                   got.pix.red, got.pix.green, got.pix.blue, got.row_last);
        return;
      end
      want = blurred_q.pop_front();
      if (got.pix.red !== want.pix.red || got.pix.green !== want.pix.green ||
          got.pix.blue !== want.pix.blue || got.row_last !== want.row_last) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("%0t: mismatch exp r=%0d g=%0d b=%0d last=%0b, got r=%0d g=%0d b=%0d last=%0b",
                   $realtime, want.pix.red, want.pix.green, want.pix.blue, want.row_last,
                   got.pix.red, got.pix.green, got.pix.blue, got.row_last);
      end
    endfunction

    function int pending();
      return blurred_q.size();
    endfunction

    function void note_leftovers();
      if (blurred_q.size() != 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("%0d expected results never arrived", blurred_q.size());
      end
    endfunction
  endclass

  logic       clk;
  logic       rst_n;
  logic       push;
  logic       full;
  logic [7:0] in_red_in;
  logic [7:0] in_green_in;
  logic [7:0] in_blue_in;
  logic       in_row_last_in;
  logic       empty;
  logic       pop;
  logic [7:0] out_red_out;
  logic [7:0] out_green_out;
  logic [7:0] out_blue_out;
  logic       out_row_last_out;

  blur_scoreboard board;
  int             pixels_sent;
  int             cycles;
  bit             sender_idles;
  bit             sink_stalls;

  horizontal_box_blur_rgb #(.BLUR_RADIUS(RADIUS)) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_red_in        (in_red_in),
    .in_green_in      (in_green_in),
    .in_blue_in       (in_blue_in),
    .in_row_last_in   (in_row_last_in),
    .empty            (empty),
    .pop              (pop),
    .out_red_out      (out_red_out),
    .out_green_out    (out_green_out),
    .out_blue_out     (out_blue_out),
    .out_row_last_out (out_row_last_out)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // result side: random stall bursts, sampled at the rising edge
  initial begin
    int stall_left;
    stall_left = 0;
    pop        = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 9) - 1;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    result_t got;
    if (rst_n && pop && !empty) begin
      got.pix.red   = out_red_out;
      got.pix.green = out_green_out;
      got.pix.blue  = out_blue_out;
      got.row_last  = out_row_last_out;
      board.check_result(got);
    end
  end

  function automatic logic [7:0] random_channel();
    int pick;
    pick = $urandom_range(0, 7);
    if (pick == 0) return 8'h00;
    if (pick == 1) return 8'hff;
    return 8'($urandom_range(0, 255));
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                            input logic last);
    pixel_t px;
    int     gap;
    if (sender_idles && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push           <= 1'b1;
    in_red_in      <= r;
    in_green_in    <= g;
    in_blue_in     <= b;
    in_row_last_in <= last;
    @(posedge clk);
    while (full) @(posedge clk);
    px.red   = r;
    px.green = g;
    px.blue  = b;
    board.note_pixel(px, last);
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic send_random_row();
    int len, pick, i;
    pick = $urandom_range(0, 19);
    if (pick < 14) len = $urandom_range(1, 10);
    else if (pick < 19) len = $urandom_range(11, 30);
    else len = $urandom_range(31, 60);
    for (i = 0; i < len; i++)
      send_pixel(random_channel(), random_channel(), random_channel(), i == len - 1);
  endtask

  task automatic wait_drained();
    while (board.pending() != 0) @(posedge clk);
  endtask

  initial begin
    int i;
    board          = new();
    pixels_sent    = 0;
    sender_idles   = 1'b1;
    sink_stalls    = 1'b1;
    rst_n          = 1'b0;
    push           = 1'b0;
    in_red_in      = 8'h00;
    in_green_in    = 8'h00;
    in_blue_in     = 8'h00;
    in_row_last_in = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // single-pixel rows at both extremes
    send_pixel(8'hff, 8'hff, 8'hff, 1'b1);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
    // rows too short to fill the window
    send_pixel(8'hff, 8'h00, 8'h80, 1'b0);
    send_pixel(8'h00, 8'hff, 8'h7f, 1'b1);
    for (i = 0; i < 3; i++)
      send_pixel(i == 1 ? 8'hff : 8'h00, 8'hff, 8'(i * 100), i == 2);
    for (i = 0; i < 4; i++)
      send_pixel(8'(255 - i), i[0] ? 8'hff : 8'h00, 8'h55, i == 3);
    // wide enough to saturate the row position, alternating extremes
    for (i = 0; i < 8; i++)
      send_pixel(i[0] ? 8'hff : 8'h00, (i % 3 == 0) ? 8'hff : 8'h00,
                 i[1] ? 8'ha5 : 8'h5a, i == 7);

    while (pixels_sent < 200) send_random_row();

    // hold off until the block has handed over everything
    push <= 1'b0;
    wait_drained();
    repeat (5) @(posedge clk);
    @(negedge clk);

    while (pixels_sent < 340) send_random_row();

    sender_idles = 1'b0;
    sink_stalls  = 1'b0;
    while (pixels_sent < 420) send_random_row();
    push <= 1'b0;

    wait_drained();
    repeat (30) @(posedge clk);
    board.note_leftovers();
    if (board.failures == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
